FILE: rtl/b64u_pkg.sv
package b64u_pkg;

  // Width of the running byte counter; it wraps at this width
  localparam int COUNT_WIDTH  = 32;
  // Width of the byte count reported on the end result
  localparam int BYTE_COUNT_W = 32;
  // Result queue depth; one input item pushes at most two results
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  // Decoding mode of the current string
  typedef enum logic [2:0] {
    RUN_DECODE = 3'b001,
    RUN_OK     = 3'b010,
    RUN_BAD    = 3'b100
  } run_mode_t;

  // Result kinds and status codes
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_END   = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_CORRUPT = 1'b1;

  // One result item
  typedef struct packed {
    logic                    kind;
    logic [7:0]              data_byte;
    logic                    status;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    run_last;
  } res_t;

  // Results produced by one input transaction, in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Space, tab, LF, VT, FF, CR
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // Alphabet lookup on the low seven bits; bit 6 set marks an invalid character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] k;
    logic [6:0] s;
    k = c[6:0];
    if ((k >= 7'h41) && (k <= 7'h5a)) begin
      s = 7'(k - 7'd65);
    end else if ((k >= 7'h61) && (k <= 7'h7a)) begin
      s = 7'(k - 7'd71);
    end else if ((k >= 7'h30) && (k <= 7'h39)) begin
      s = 7'(k + 7'd4);
    end else if (k == 7'h2d) begin
      s = 7'h3e;
    end else if (k == 7'h5f) begin
      s = 7'h3f;
    end else begin
      s = 7'h40;
    end
    return s;
  endfunction

endpackage

FILE: rtl/b64u_core.sv
module b64u_core
  import b64u_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] ch,
  input  logic       fin,
  output push_t      push
);

  // Decoder state
  logic [1:0]             group_phase, group_phase_next;
  logic [7:0]             held_first_char, held_first_char_next;
  logic [5:0]             prev_sextet, prev_sextet_next;
  run_mode_t              run_mode, run_mode_next;
  logic                   first_item;
  logic [COUNT_WIDTH-1:0] decoded_count, decoded_count_next;

  logic [6:0] s_cur;
  logic [6:0] s_held;
  logic       emit;
  logic [7:0] dbyte;
  res_t       r_data;
  res_t       r_end;

  assign s_cur  = sextet_of(ch);
  assign s_held = sextet_of(held_first_char);

  // Group position decode
  always_comb begin
    group_phase_next     = group_phase;
    held_first_char_next = held_first_char;
    prev_sextet_next     = prev_sextet;
    run_mode_next        = run_mode;
    emit                 = 1'b0;
    dbyte                = 8'h00;
    if (run_mode == RUN_DECODE) begin
      case (group_phase)
        2'd0: begin
          if (fin) begin
            if (first_item) run_mode_next = RUN_BAD;
          end else begin
            held_first_char_next = ch;
            group_phase_next     = 2'd1;
          end
        end
        2'd1: begin
          if (is_ws(held_first_char) || is_ws(ch)) begin
            run_mode_next = RUN_OK;
          end else if (s_held[6] || s_cur[6]) begin
            run_mode_next = RUN_BAD;
          end else begin
            dbyte            = {s_held[5:0], s_cur[5:4]};
            emit             = 1'b1;
            prev_sextet_next = s_cur[5:0];
            group_phase_next = 2'd2;
          end
        end
        2'd2: begin
          if (is_ws(ch)) begin
            run_mode_next = RUN_OK;
          end else if (s_cur[6]) begin
            run_mode_next = RUN_BAD;
          end else begin
            dbyte            = {prev_sextet[3:0], s_cur[5:2]};
            emit             = 1'b1;
            prev_sextet_next = s_cur[5:0];
            group_phase_next = 2'd3;
          end
        end
        default: begin
          if (is_ws(ch)) begin
            run_mode_next = RUN_OK;
          end else if (s_cur[6]) begin
            run_mode_next = RUN_BAD;
          end else begin
            dbyte            = {prev_sextet[1:0], s_cur[5:0]};
            emit             = 1'b1;
            prev_sextet_next = 6'd0;
            group_phase_next = 2'd0;
          end
        end
      endcase
    end
    decoded_count_next = decoded_count + COUNT_WIDTH'(emit);
  end

  // Result items
  always_comb begin
    r_data            = '0;
    r_data.kind       = KIND_DATA;
    r_data.data_byte  = dbyte;
    r_data.status     = ST_OK;
    r_data.run_last   = !fin;

    r_end             = '0;
    r_end.kind        = KIND_END;
    r_end.run_last    = 1'b1;
    if (run_mode_next == RUN_BAD) begin
      r_end.status     = ST_CORRUPT;
      r_end.byte_count = '0;
    end else begin
      r_end.status     = ST_OK;
      r_end.byte_count = BYTE_COUNT_W'(decoded_count_next);
    end

    push    = '0;
    push.r1 = r_end;
    if (step) begin
      push.n  = 2'(emit) + 2'(fin);
      push.r0 = emit ? r_data : r_end;
    end else begin
      push.n  = 2'd0;
      push.r0 = r_data;
    end
  end

  // State registers; the final character returns everything to reset
  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase     <= 2'd0;
      held_first_char <= 8'h00;
      prev_sextet     <= 6'd0;
      run_mode        <= RUN_DECODE;
      first_item      <= 1'b1;
      decoded_count   <= '0;
    end else if (step) begin
      if (fin) begin
        group_phase     <= 2'd0;
        held_first_char <= 8'h00;
        prev_sextet     <= 6'd0;
        run_mode        <= RUN_DECODE;
        first_item      <= 1'b1;
        decoded_count   <= '0;
      end else begin
        group_phase     <= group_phase_next;
        held_first_char <= held_first_char_next;
        prev_sextet     <= prev_sextet_next;
        run_mode        <= run_mode_next;
        first_item      <= 1'b0;
        decoded_count   <= decoded_count_next;
      end
    end
  end

  // A final character leaves the decoder as after reset
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    step && fin |=> group_phase == 2'd0 && first_item && decoded_count == '0
                    && run_mode == RUN_DECODE)
    else $error("final character did not clear decoder state");

  // Once decoding has ended, only the final character produces a result
  a_ended_quiet: assert property (@(posedge clk) disable iff (rst)
    step && run_mode != RUN_DECODE && !fin |-> push.n == 2'd0)
    else $error("result produced after decoding ended");

  // The last pushed result carries run_last
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> !push.r0.run_last && push.r1.run_last)
    else $error("run_last misplaced in a two-result transaction");

endmodule

FILE: rtl/b64u_out_fifo.sv
module b64u_out_fifo
  import b64u_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  out_res
);

  res_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_p1;

  // Room for the worst case of two results per transaction
  assign room      = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign wr_ptr_p1 = wr_ptr + FIFO_AW'(1);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.n == 2'd2) mem[wr_ptr_p1] <= push.r1;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.n);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count  <= count + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> room)
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue fill level out of range");

  // A stalled result stays offered and unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("stalled result changed or was dropped");

endmodule

FILE: rtl/base64url_stream_decoder.sv
// URL-safe base64 stream decoder, unpadded.
// Input channel: one character per transaction on char_in, with final_char
// high on the last character of the string (in_valid / in_stall).
// Output channel: decoded bytes (kind 0) and one end-of-string result
// (kind 1) with status and byte_count (out_valid / out_stall). run_last
// marks the last result caused by an input character; one character gives
// zero, one or two results.
// A result is offered on out_valid once its character has gone from the
// input register through the decode logic into the four-entry result
// queue; without room in the queue, the character waits in the register.
// Throughput: one character per cycle. The input register advances while
// the result queue has space for two results, so a sustained rate of one
// per cycle holds as long as results are taken at least as fast as made.
// When the receiver stalls, the queue fills and in_stall rises; the
// offered result holds until taken.
// Reset clears the decoder state, the input register and the queue; the
// block is ready for a new string as soon as reset is released.
module base64url_stream_decoder
  import b64u_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              char_in,
  input  logic                    final_char,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    kind,
  output logic [7:0]              data_byte,
  output logic                    status,
  output logic [BYTE_COUNT_W-1:0] byte_count,
  output logic                    run_last
);

  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       fin_q;
  logic       room;
  logic       step;
  push_t      push;
  res_t       out_res;

  // Input register advances into the decoder when the queue has room
  assign step     = in_vld_q && room;
  assign in_stall = in_vld_q && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch_q  <= char_in;
      fin_q <= final_char;
    end
  end

  b64u_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .ch   (ch_q),
    .fin  (fin_q),
    .push (push)
  );

  b64u_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Result fields
  assign kind       = out_res.kind;
  assign data_byte  = out_res.data_byte;
  assign status     = out_res.status;
  assign byte_count = out_res.byte_count;
  assign run_last   = out_res.run_last;

endmodule
